// ----- design/fee_pkg.sv -----
// Shared types, codes and constants of the flash EEPROM emulation core.
package fee_pkg;

  localparam int PAGE_WORDS_DEF = 256;
  localparam int PAGE_COUNT_DEF = 4;
  localparam int WORD_W         = 32;
  localparam int HDR_WORDS      = 4;

  localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] FILL_WORD   = 32'h0000_00FF;

  typedef enum logic [1:0] {
    CMD_GET  = 2'd0,
    CMD_SET  = 2'd1,
    CMD_LOAD = 2'd2,
    CMD_SAVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_VERSION = 2'd0,
    CFG_START   = 2'd1,
    CFG_END     = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_GET,
    OP_SET,
    OP_SAVE,
    OP_CLEAR,
    OP_FILL,
    OP_LREAD,
    OP_LPASS,
    OP_LFAIL,
    OP_SREAD,
    OP_SHDR,
    OP_SLAST
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic page_ok;
  } dp_stat_t;

endpackage

// ----- design/fee_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module fee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/fee_ctrl.sv -----
// Controller state machine: sequences commands, page scans, copies and sweeps.
module fee_ctrl #(
  parameter int PAGE_WORDS = fee_pkg::PAGE_WORDS_DEF,
  parameter int PAGE_COUNT = fee_pkg::PAGE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    in_cmd,
  output logic                          busy,
  output fee_pkg::dp_cmd_t              cmd,
  input  fee_pkg::dp_stat_t             stat,
  output logic [$clog2(PAGE_WORDS)-1:0] cnt,
  output logic [$clog2(PAGE_COUNT)-1:0] pg
);

  localparam int WA          = $clog2(PAGE_WORDS);
  localparam int PA          = $clog2(PAGE_COUNT);
  localparam int STORE_WORDS = PAGE_WORDS - fee_pkg::HDR_WORDS;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LSCAN,
    S_LLAST,
    S_LDEC,
    S_FILL,
    S_LFIN,
    S_SCOPY,
    S_SDRAIN,
    S_SHDR,
    S_SLAST
  } state_t;

  state_t          state_r, state_nxt;
  logic [WA-1:0]   cnt_r, cnt_nxt;
  logic [PA-1:0]   pg_r, pg_nxt;
  fee_pkg::dp_op_t op;
  logic            store_end;
  logic            page_end;
  logic            last_page;

  assign store_end = (cnt_r == WA'(STORE_WORDS - 1));
  assign page_end  = (cnt_r == WA'(PAGE_WORDS - 1));
  assign last_page = (pg_r == PA'(PAGE_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pg_nxt    = pg_r;
    op        = fee_pkg::OP_NONE;
    case (state_r)
      S_CLEAR: begin
        op = fee_pkg::OP_CLEAR;
        if (store_end) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + WA'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          case (in_cmd)
            fee_pkg::CMD_GET: op = fee_pkg::OP_GET;
            fee_pkg::CMD_SET: op = fee_pkg::OP_SET;
            fee_pkg::CMD_LOAD: begin
              pg_nxt    = '0;
              state_nxt = S_LSCAN;
            end
            fee_pkg::CMD_SAVE: begin
              op        = fee_pkg::OP_SAVE;
              state_nxt = S_SCOPY;
            end
            default: op = fee_pkg::OP_NONE;
          endcase
        end
      end
      S_LSCAN: begin
        op = fee_pkg::OP_LREAD;
        if (page_end) begin
          cnt_nxt   = '0;
          state_nxt = S_LLAST;
        end else begin
          cnt_nxt = cnt_r + WA'(1);
        end
      end
      S_LLAST: state_nxt = S_LDEC;
      S_LDEC: begin
        if (stat.page_ok) begin
          op        = fee_pkg::OP_LPASS;
          state_nxt = S_IDLE;
        end else if (last_page) begin
          state_nxt = S_FILL;
        end else begin
          pg_nxt    = pg_r + PA'(1);
          state_nxt = S_LSCAN;
        end
      end
      S_FILL: begin
        op = fee_pkg::OP_FILL;
        if (store_end) begin
          cnt_nxt   = '0;
          state_nxt = S_LFIN;
        end else begin
          cnt_nxt = cnt_r + WA'(1);
        end
      end
      S_LFIN: begin
        op        = fee_pkg::OP_LFAIL;
        state_nxt = S_IDLE;
      end
      S_SCOPY: begin
        op = fee_pkg::OP_SREAD;
        if (store_end) begin
          cnt_nxt   = '0;
          state_nxt = S_SDRAIN;
        end else begin
          cnt_nxt = cnt_r + WA'(1);
        end
      end
      S_SDRAIN: state_nxt = S_SHDR;
      S_SHDR: begin
        op = fee_pkg::OP_SHDR;
        if (cnt_r == WA'(2)) begin
          cnt_nxt   = '0;
          state_nxt = S_SLAST;
        end else begin
          cnt_nxt = cnt_r + WA'(1);
        end
      end
      S_SLAST: begin
        op        = fee_pkg::OP_SLAST;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      pg_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pg_r    <= pg_nxt;
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign cmd.op = op;
  assign cnt    = cnt_r;
  assign pg     = pg_r;

  a_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LDEC && stat.page_ok) |=> (state_r == S_IDLE))
    else $error("load did not finish after a valid page");

  a_long_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == fee_pkg::CMD_LOAD || in_cmd == fee_pkg::CMD_SAVE))
    |=> busy)
    else $error("load or save accepted without raising busy");

  a_fill_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> last_page)
    else $error("fill started before every page was scanned");

endmodule

// ----- design/fee_dp.sv -----
// Datapath: shadow image, modelled flash, checksum, page tracking and result registers.
module fee_dp #(
  parameter int PAGE_WORDS = fee_pkg::PAGE_WORDS_DEF,
  parameter int PAGE_COUNT = fee_pkg::PAGE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic [7:0]                    in_word_index,
  input  logic [31:0]                   in_write_value,
  input  fee_pkg::dp_cmd_t              cmd,
  output fee_pkg::dp_stat_t             stat,
  input  logic [$clog2(PAGE_WORDS)-1:0] cnt,
  input  logic [$clog2(PAGE_COUNT)-1:0] pg,
  output logic                          out_strobe,
  output logic                          out_ok,
  output logic [31:0]                   out_read_value,
  output logic [3:0]                    out_page_index
);

  localparam int WA          = $clog2(PAGE_WORDS);
  localparam int PA          = $clog2(PAGE_COUNT);
  localparam int STORE_WORDS = PAGE_WORDS - fee_pkg::HDR_WORDS;
  localparam int SA          = $clog2(STORE_WORDS);
  localparam int FL_DEPTH    = PAGE_COUNT * (2 ** WA);
  localparam int W           = fee_pkg::WORD_W;

  logic [W-1:0]          ver_r, start_r, end_r;
  logic [W-1:0]          hdr_start_r, hdr_ver_r, hdr_end_r;
  logic [PA-1:0]         cur_page_r;
  logic [PAGE_COUNT-1:0] erased_r;
  logic [PA-1:0]         tgt;

  logic                  ld_v_r;
  logic [WA-1:0]         ld_w_r;
  logic                  rd_erased_r;
  logic                  ld_ok_r;
  logic [W-1:0]          chk_r;
  logic [W-1:0]          sum_r;
  logic                  sv_v_r;
  logic [WA-1:0]         sv_w_r;

  logic                  res_v_r, res_get_r, res_ok_r;
  logic                  out_strobe_r, out_ok_r;
  logic [W-1:0]          out_rd_r;
  logic [3:0]            out_pg_r;

  logic                  idx_ok;
  logic [SA+7:0]         idx_ext;
  logic [WA-1:0]         ld_off;
  logic [WA-1:0]         sv_word;
  logic                  ld_copy;

  logic                  sh_we, sh_re;
  logic [SA-1:0]         sh_waddr, sh_raddr;
  logic [W-1:0]          sh_wdata, sh_rdata;
  logic                  fl_we, fl_re;
  logic [PA+WA-1:0]      fl_waddr, fl_raddr;
  logic [W-1:0]          fl_wdata, fl_rdata, fl_data;

  assign idx_ok  = (32'(in_word_index) < 32'(STORE_WORDS));
  assign idx_ext = {{SA{1'b0}}, in_word_index};
  assign ld_off  = ld_w_r - WA'(3);
  assign sv_word = sv_w_r + WA'(3);
  assign tgt     = (cur_page_r == PA'(PAGE_COUNT - 1)) ? '0 : cur_page_r + PA'(1);
  assign fl_data = rd_erased_r ? fee_pkg::ERASED_WORD : fl_rdata;
  assign ld_copy = ld_v_r && (ld_w_r > WA'(2)) && (ld_w_r != WA'(PAGE_WORDS - 1));

  always_comb begin
    sh_we    = 1'b0;
    sh_waddr = cnt[SA-1:0];
    sh_wdata = '0;
    sh_re    = 1'b0;
    sh_raddr = cnt[SA-1:0];
    case (cmd.op)
      fee_pkg::OP_SET: begin
        sh_we    = idx_ok;
        sh_waddr = idx_ext[SA-1:0];
        sh_wdata = in_write_value;
      end
      fee_pkg::OP_GET: begin
        sh_re    = idx_ok;
        sh_raddr = idx_ext[SA-1:0];
      end
      fee_pkg::OP_CLEAR: sh_we = 1'b1;
      fee_pkg::OP_FILL: begin
        sh_we    = 1'b1;
        sh_wdata = fee_pkg::FILL_WORD;
      end
      fee_pkg::OP_SREAD: sh_re = 1'b1;
      default: sh_we = 1'b0;
    endcase
    if (ld_copy) begin
      sh_we    = 1'b1;
      sh_waddr = ld_off[SA-1:0];
      sh_wdata = fl_data;
    end
  end

  always_comb begin
    fl_re    = (cmd.op == fee_pkg::OP_LREAD);
    fl_raddr = {pg, cnt};
    fl_we    = 1'b0;
    fl_waddr = {tgt, sv_word};
    fl_wdata = sh_rdata;
    if (sv_v_r) begin
      fl_we = 1'b1;
    end else if (cmd.op == fee_pkg::OP_SHDR) begin
      fl_we    = 1'b1;
      fl_waddr = {tgt, cnt};
      if (cnt == WA'(0)) begin
        fl_wdata = hdr_start_r;
      end else if (cnt == WA'(1)) begin
        fl_wdata = hdr_ver_r;
      end else begin
        fl_wdata = sum_r;
      end
    end else if (cmd.op == fee_pkg::OP_SLAST) begin
      fl_we    = 1'b1;
      fl_waddr = {tgt, WA'(PAGE_WORDS - 1)};
      fl_wdata = hdr_end_r;
    end
  end

  fee_ram #(.WIDTH(W), .DEPTH(STORE_WORDS)) u_shadow (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (sh_wdata),
    .re    (sh_re),
    .raddr (sh_raddr),
    .rdata (sh_rdata)
  );

  fee_ram #(.WIDTH(W), .DEPTH(FL_DEPTH)) u_flash (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .re    (fl_re),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r        <= '0;
      start_r      <= '0;
      end_r        <= '0;
      hdr_start_r  <= '0;
      hdr_ver_r    <= '0;
      hdr_end_r    <= '0;
      cur_page_r   <= '0;
      erased_r     <= '1;
      ld_v_r       <= 1'b0;
      sv_v_r       <= 1'b0;
      res_v_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fee_pkg::CFG_VERSION: ver_r   <= cfg_wdata;
          fee_pkg::CFG_START:   start_r <= cfg_wdata;
          fee_pkg::CFG_END:     end_r   <= cfg_wdata;
          default:              ver_r   <= ver_r;
        endcase
      end
      ld_v_r       <= (cmd.op == fee_pkg::OP_LREAD);
      sv_v_r       <= (cmd.op == fee_pkg::OP_SREAD);
      out_strobe_r <= res_v_r;
      case (cmd.op)
        fee_pkg::OP_GET, fee_pkg::OP_SET: res_v_r <= 1'b1;
        fee_pkg::OP_LPASS: begin
          res_v_r     <= 1'b1;
          cur_page_r  <= pg;
          hdr_start_r <= start_r;
          hdr_ver_r   <= ver_r;
          hdr_end_r   <= end_r;
        end
        fee_pkg::OP_LFAIL: begin
          res_v_r     <= 1'b1;
          cur_page_r  <= PA'(PAGE_COUNT - 1);
          hdr_start_r <= start_r;
          hdr_ver_r   <= ver_r;
          hdr_end_r   <= end_r;
        end
        fee_pkg::OP_SLAST: begin
          res_v_r              <= 1'b1;
          cur_page_r           <= tgt;
          erased_r[tgt]        <= 1'b0;
          erased_r[cur_page_r] <= 1'b1;
        end
        default: res_v_r <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ld_w_r <= cnt;
    sv_w_r <= cnt;
    if (cmd.op == fee_pkg::OP_LREAD) begin
      rd_erased_r <= erased_r[pg];
    end
    if (cmd.op == fee_pkg::OP_SAVE) begin
      sum_r <= hdr_ver_r;
    end else if (sv_v_r) begin
      sum_r <= sum_r + sh_rdata;
    end else if (ld_v_r) begin
      if (ld_w_r == WA'(0)) begin
        ld_ok_r <= (fl_data == start_r);
      end else if (ld_w_r == WA'(1)) begin
        ld_ok_r <= ld_ok_r && (fl_data == ver_r);
        sum_r   <= fl_data;
      end else if (ld_w_r == WA'(2)) begin
        chk_r <= fl_data;
      end else if (ld_w_r == WA'(PAGE_WORDS - 1)) begin
        ld_ok_r <= ld_ok_r && (fl_data == end_r);
      end else begin
        sum_r <= sum_r + fl_data;
      end
    end
    case (cmd.op)
      fee_pkg::OP_GET: begin
        res_get_r <= 1'b1;
        res_ok_r  <= idx_ok;
      end
      fee_pkg::OP_SET: begin
        res_get_r <= 1'b0;
        res_ok_r  <= idx_ok;
      end
      fee_pkg::OP_LFAIL: begin
        res_get_r <= 1'b0;
        res_ok_r  <= 1'b0;
      end
      fee_pkg::OP_LPASS, fee_pkg::OP_SLAST: begin
        res_get_r <= 1'b0;
        res_ok_r  <= 1'b1;
      end
      default: res_get_r <= res_get_r;
    endcase
    out_ok_r <= res_ok_r;
    out_rd_r <= (res_get_r && res_ok_r) ? sh_rdata : '0;
    out_pg_r <= 4'(cur_page_r);
  end

  assign stat.page_ok   = ld_ok_r && (sum_r == chk_r);
  assign out_strobe     = out_strobe_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rd_r;
  assign out_page_index = out_pg_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_ok) |-> (out_read_value == '0))
    else $error("failed word carries a non-zero read value");

  a_save_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == fee_pkg::OP_SLAST) |=> !erased_r[cur_page_r])
    else $error("saved page still marked erased");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    sv_v_r |-> (cmd.op != fee_pkg::OP_SHDR && cmd.op != fee_pkg::OP_SLAST))
    else $error("two flash writes in one cycle");

endmodule

// ----- design/flash_eeprom_emulation_core.sv -----
// Top level of the flash EEPROM emulation core: controller plus datapath.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+------------------------
//  input   | in_cmd, in_word_index, in_write_value        | start high, busy low
//  result  | out_ok, out_read_value, out_page_index       | out_strobe, one cycle
//  config  | cfg_index, cfg_wdata                         | cfg_we, no wait
//
// Get and set may follow back to back; the word passes through the result registers and
// then the output registers. Load scans one page at a time through the single flash read
// port, then fills the storage when no page is valid. Save copies the storage through the
// shadow read port and flash write port. After reset the shadow storage is cleared with busy
// high. The receiver cannot stall: each word is on the outputs for exactly one cycle.
module flash_eeprom_emulation_core #(
  parameter int PAGE_WORDS = fee_pkg::PAGE_WORDS_DEF,
  parameter int PAGE_COUNT = fee_pkg::PAGE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_word_index,
  input  logic [31:0] in_write_value,
  output logic        out_strobe,
  output logic        out_ok,
  output logic [31:0] out_read_value,
  output logic [3:0]  out_page_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int WA = $clog2(PAGE_WORDS);
  localparam int PA = $clog2(PAGE_COUNT);

  fee_pkg::dp_cmd_t  cmd;
  fee_pkg::dp_stat_t stat;
  logic [WA-1:0]     cnt;
  logic [PA-1:0]     pg;

  fee_ctrl #(.PAGE_WORDS(PAGE_WORDS), .PAGE_COUNT(PAGE_COUNT)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .busy   (busy),
    .cmd    (cmd),
    .stat   (stat),
    .cnt    (cnt),
    .pg     (pg)
  );

  fee_dp #(.PAGE_WORDS(PAGE_WORDS), .PAGE_COUNT(PAGE_COUNT)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_word_index  (in_word_index),
    .in_write_value (in_write_value),
    .cmd            (cmd),
    .stat           (stat),
    .cnt            (cnt),
    .pg             (pg),
    .out_strobe     (out_strobe),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_page_index (out_page_index)
  );

endmodule
